[design/murmur3_hash_stream_top_defines.svh]
// Assertion macros for the murmur3 hash stream block.
`ifndef MURMUR3_HASH_STREAM_TOP_DEFINES_SVH
`define MURMUR3_HASH_STREAM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MH3_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mh3 assertion failed");
`define MH3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mh3 next-cycle assertion failed");
`else
`define MH3_ASSERT(lbl, prop)
`define MH3_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/mh3_pkg.sv]
// Shared types, constants and helpers for the murmur3 hash stream block.
package mh3_pkg;

	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;
	localparam logic [2:0]  FULL_COUNT = 3'd4;

	typedef struct packed {
		logic [31:0] key;
		logic [2:0]  count;
		logic        last;
	} mh3_item_t;

	typedef enum logic [1:0] {
		ST_MIX,
		ST_AV1,
		ST_AV2,
		ST_AV3
	} mh3_state_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} mh3_front_stat_t;

	typedef struct packed {
		mh3_state_t fsm;
	} mh3_back_stat_t;

	function automatic logic [31:0] byte_mask(input logic [2:0] count);
		logic [31:0] m;
		case (count)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00ff;
			3'd2: m = 32'h0000_ffff;
			3'd3: m = 32'h00ff_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

endpackage

[design/murmur3_hash_stream_top.sv]
// Streaming MurmurHash3 (32-bit) top level.
// Input channel: in_valid/in_ready carry data_word (first byte in bits 7:0),
// byte_count (0..4, larger counts act as 4) and last. A beat with fewer than
// four bytes ends the message. Output channel: out_valid/out_ready carry hash,
// one beat per message. seed_we/seed_wdata write the seed; it is picked up on
// the first beat of each message.
// Throughput: one input beat per cycle for full words while the queue has room;
// a message-ending beat occupies the mixer for the mix step plus three avalanche
// steps, two of them bounded by one 32x32 multiplier.
// Path from last input beat to hash: two scramble stages, queue, mix, two
// multiply stages of the avalanche, result register.
// A FIFO_DEPTH-entry queue decouples the scrambler from the mixer, so input
// beats keep flowing while the mixer finishes a hash or the receiver stalls.
// When out_ready is low the result register holds its beat and the back end
// waits; the front keeps taking beats until the queue fills.
// Reset clears the pipeline, queue, running hash, byte total and seed (to 0).
module murmur3_hash_stream_top #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash
);
	import mh3_pkg::*;

	`include "murmur3_hash_stream_top_defines.svh"

	logic [31:0]     seed_q;
	mh3_item_t       f_item, q_item;
	logic            f_valid, q_not_full, q_not_empty, q_pop;
	mh3_front_stat_t fstat;
	mh3_back_stat_t  bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	mh3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.item_valid (f_valid),
		.item_ready (q_not_full),
		.item       (f_item),
		.stat       (fstat)
	);

	mh3_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_item (f_item),
		.not_full  (q_not_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_item  (q_item)
	);

	mh3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.q_valid   (q_not_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hash      (hash),
		.stat      (bstat)
	);

	`MH3_ASSERT(a_pop_only_in_mix, (bstat.fsm != ST_MIX) |-> !q_pop)
	`MH3_ASSERT(a_result_from_avalanche, $rose(out_valid) |-> ($past(bstat.fsm) == ST_AV3))
	`MH3_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, fstat.v_s1)
	`MH3_ASSERT(a_s2_push_when_room, (fstat.v_s2 && q_not_full) |-> f_valid)

endmodule

[design/mh3_fifo.sv]
// Small register queue between the key scrambler and the hash mixer.
module mh3_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mh3_pkg::mh3_item_t push_item,
	output logic            not_full,
	output logic            not_empty,
	input  logic            pop,
	output mh3_pkg::mh3_item_t pop_item
);
	import mh3_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mh3_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign not_full  = (cnt_q != CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/mh3_front.sv]
// Front end: input beat intake, count classification and two-stage key scramble.
module mh3_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [31:0]             data_word,
	input  logic [2:0]              byte_count,
	input  logic                    last,
	output logic                    item_valid,
	input  logic                    item_ready,
	output mh3_pkg::mh3_item_t      item,
	output mh3_pkg::mh3_front_stat_t stat
);
	import mh3_pkg::*;

	logic        v_s1, v_s2;
	logic [31:0] k_s1, k_s2;
	logic [2:0]  cnt_s1, cnt_s2;
	logic        last_s1, last_s2;
	logic        adv1, adv2;
	logic [2:0]  cnt_sat;
	logic [31:0] k_mul1;
	logic [31:0] k_rot;
	logic [31:0] k_mul2;

	assign adv2     = !v_s2 || item_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign cnt_sat = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
	assign k_mul1  = (data_word & byte_mask(cnt_sat)) * MIX_C1;
	assign k_rot   = {k_s1[16:0], k_s1[31:17]};
	assign k_mul2  = k_rot * MIX_C2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			k_s1    <= k_mul1;
			cnt_s1  <= cnt_sat;
			last_s1 <= last || (cnt_sat != FULL_COUNT);
		end
		if (adv2 && v_s1) begin
			k_s2    <= k_mul2;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	assign item_valid = v_s2;
	assign item.key   = k_s2;
	assign item.count = cnt_s2;
	assign item.last  = last_s2;
	assign stat.v_s1  = v_s1;
	assign stat.v_s2  = v_s2;

endmodule

[design/mh3_back.sv]
// Back end: running hash update, byte total, final avalanche and result register.
module mh3_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [31:0]            seed,
	input  logic                   q_valid,
	input  mh3_pkg::mh3_item_t     q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            hash,
	output mh3_pkg::mh3_back_stat_t stat
);
	import mh3_pkg::*;

	mh3_state_t  state_q, state_d;
	logic [31:0] run_q;
	logic [31:0] tot_q;
	logic        at_start_q;
	logic [31:0] fin_q;
	logic [31:0] hash_q;
	logic        out_valid_q;

	logic [31:0] h_base, tot_new, h_x, h_rot, h_mix;
	logic        out_load;
	logic [31:0] av1_x, av2_x;

	assign h_base  = at_start_q ? seed : run_q;
	assign tot_new = (at_start_q ? 32'd0 : tot_q) + {29'd0, q_item.count};
	assign h_x     = h_base ^ q_item.key;
	assign h_rot   = {h_x[18:0], h_x[31:19]};
	assign h_mix   = (q_item.count == FULL_COUNT) ?
		(h_rot + {h_rot[29:0], 2'b00} + MIX_ADD) : h_x;
	assign av1_x   = fin_q ^ {16'd0, fin_q[31:16]};
	assign av2_x   = fin_q ^ {13'd0, fin_q[31:13]};
	assign out_load = (state_q == ST_AV3) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			ST_MIX: begin
				q_pop = q_valid;
				if (q_valid && q_item.last) begin
					state_d = ST_AV1;
				end
			end
			ST_AV1: state_d = ST_AV2;
			ST_AV2: state_d = ST_AV3;
			ST_AV3: begin
				if (out_load) begin
					state_d = ST_MIX;
				end
			end
			default: state_d = ST_MIX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MIX;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			tot_q       <= '0;
			at_start_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.last) begin
					run_q      <= '0;
					tot_q      <= '0;
					at_start_q <= 1'b1;
				end else begin
					run_q      <= h_mix;
					tot_q      <= tot_new;
					at_start_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MIX: fin_q <= h_mix ^ tot_new;
			ST_AV1: fin_q <= av1_x * FIN_C1;
			ST_AV2: fin_q <= av2_x * FIN_C2;
			default: fin_q <= fin_q;
		endcase
		if (out_load) begin
			hash_q <= av1_x;
		end
	end

	assign out_valid = out_valid_q;
	assign hash      = hash_q;
	assign stat.fsm  = state_q;

endmodule

[sim/testbench.sv]
// Self-checking testbench for murmur3_hash_stream_top: random messages, seeds and handshake stalls.
`timescale 1ns / 1ps

module testbench;
	import mh3_pkg::*;

	localparam int PHASE_BEATS = 250;
	localparam int NUM_PHASES = 7;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 16;
	localparam int LONG_HOLD = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_we = 1'b0;
	logic [31:0] seed_wdata = 32'h0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = 32'h0;
	logic [2:0]  byte_count = 3'd0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] hash;

	mh3_item_t   beats_pending[$];
	logic [31:0] hash_due[$];
	logic [31:0] cfg_seed = 32'h0;
	logic [31:0] run_hash = 32'h0;
	logic [31:0] run_bytes = 32'h0;
	logic        msg_open = 1'b0;
	logic        in_taken = 1'b0;
	int          mismatches = 0;
	int          idle_odds = 8;
	int          send_gap = 0;
	int          rx_gap = 0;
	int          rx_hold = 0;
	int          long_stall_req = 0;
	int          long_stall_done = 0;

	murmur3_hash_stream_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash       (hash)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic logic [31:0] scramble_word(input logic [31:0] k);
		logic [31:0] t;
		t = k * MIX_C1;
		t = rotl(t, 15);
		t = t * MIX_C2;
		return t;
	endfunction

	function automatic logic [31:0] avalanche_hash(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * FIN_C1;
		t = t ^ (t >> 13);
		t = t * FIN_C2;
		t = t ^ (t >> 16);
		return t;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH @%0t: %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Running hash update for one accepted beat; queues the hash when the message ends.
	task automatic absorb_beat(input logic [31:0] word, input logic [2:0] cnt,
		input logic fin_flag);
		logic [31:0] h;
		logic [31:0] tot;
		logic [31:0] mask;
		logic [2:0]  c;
		logic        fin;
		c = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
		fin = fin_flag;
		h = msg_open ? run_hash : cfg_seed;
		tot = msg_open ? run_bytes : 32'h0;
		if (c == FULL_COUNT) begin
			h = h ^ scramble_word(word);
			h = rotl(h, 13);
			h = h * 32'd5 + MIX_ADD;
		end else begin
			mask = (c == 3'd0) ? 32'h0 : (32'hffff_ffff >> (32 - 8 * c));
			h = h ^ scramble_word(word & mask);
			fin = 1'b1;
		end
		tot = tot + {29'b0, c};
		if (fin) begin
			hash_due.push_back(avalanche_hash(h ^ tot));
			msg_open = 1'b0;
		end else begin
			run_hash = h;
			run_bytes = tot;
			msg_open = 1'b1;
		end
	endtask

	task automatic push_beat(input logic [31:0] key, input logic [2:0] cnt,
		input logic fin_flag);
		mh3_item_t it;
		it.key = key;
		it.count = cnt;
		it.last = fin_flag;
		beats_pending.push_back(it);
	endtask

	// Wait until every beat is in and every hash is out, then let the pipeline empty.
	task automatic settle();
		int waited;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while ((beats_pending.size() != 0 || in_valid || hash_due.size() != 0)
			&& waited < DRAIN_LIMIT);
		if (hash_due.size() != 0) begin
			flag_mismatch("hash never arrived", 32'h0, hash_due[0]);
			hash_due.delete();
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		settle();
		seed_wdata <= v;
		seed_we <= 1'b1;
		cfg_seed = v;
		@(negedge clk);
		seed_we <= 1'b0;
	endtask

	always @(negedge clk) begin : driver
		mh3_item_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (beats_pending.size() != 0) begin
				nxt = beats_pending.pop_front();
				data_word <= nxt.key;
				byte_count <= nxt.count;
				last <= nxt.last;
				in_valid <= 1'b1;
				if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
					send_gap = $urandom_range(1, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (long_stall_req != long_stall_done) begin
				long_stall_done = long_stall_req;
				rx_hold = LONG_HOLD;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
					rx_gap = $urandom_range(1, 16);
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic [31:0] want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (hash_due.size() == 0) begin
					flag_mismatch("unexpected hash beat", hash, 32'h0);
				end else begin
					want = hash_due.pop_front();
					if (hash !== want)
						flag_mismatch("hash", hash, want);
				end
			end
			if (in_valid && in_ready)
				absorb_beat(data_word, byte_count, last);
		end else begin
			in_taken <= 1'b0;
		end
	end

	initial begin : stimulus
		int          sent;
		int          nwords;
		logic [31:0] s;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty and short words, oversized counts, reset seed
		push_beat(32'h0000_0000, 3'd0, 1'b0);
		push_beat(32'hffff_ffff, 3'd0, 1'b1);
		push_beat(32'hffff_ffff, 3'd1, 1'b0);
		push_beat(32'h12a5_a5ff, 3'd2, 1'b1);
		push_beat(32'hffff_ffff, 3'd3, 1'b0);
		push_beat(32'hffff_ffff, 3'd4, 1'b1);
		push_beat(32'h0000_0000, 3'd4, 1'b0);
		push_beat(32'hffff_ffff, 3'd5, 1'b0);
		push_beat(32'h8000_0001, 3'd6, 1'b0);
		push_beat(32'h7fff_fffe, 3'd7, 1'b1);
		push_beat(32'hdead_beef, 3'd4, 1'b0);
		push_beat(32'h0123_4567, 3'd4, 1'b0);
		push_beat(32'hffff_ffff, 3'd0, 1'b1);
		push_beat(32'h89ab_cdef, 3'd4, 1'b0);
		push_beat(32'hffff_ffff, 3'd3, 1'b0);
		push_beat(32'h5555_aaaa, 3'd4, 1'b0);
		push_beat(32'haaaa_5555, 3'd4, 1'b0);
		// seed written with a message open: only the next message sees it
		write_seed(32'hffff_ffff);
		push_beat(32'hcafe_f00d, 3'd4, 1'b1);
		push_beat(32'h0000_0000, 3'd0, 1'b1);
		push_beat(32'hffff_ffff, 3'd4, 1'b1);
		push_beat(32'h0000_0000, 3'd4, 1'b1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: s = 32'h0000_0000;
				3: s = 32'hffff_ffff;
				default: s = $urandom;
			endcase
			write_seed(s);
			case ($urandom_range(0, 3))
				0: idle_odds = 3;
				1: idle_odds = 6;
				2: idle_odds = 12;
				default: idle_odds = 40;
			endcase
			if (ph == NUM_PHASES - 1)
				idle_odds = 0;
			if (ph == 2)
				long_stall_req++;
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if ($urandom_range(0, 19) == 0) begin
					push_beat($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
					sent++;
				end else begin
					nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
						: $urandom_range(0, 5);
					for (int w = 0; w < nwords; w++)
						push_beat(rand_word(),
							($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : FULL_COUNT,
							1'b0);
					if (nwords > 0 && $urandom_range(0, 1) == 0)
						push_beat(rand_word(), 3'($urandom_range(4, 7)), 1'b1);
					else
						push_beat(rand_word(), 3'($urandom_range(0, 3)),
							1'($urandom_range(0, 1)));
					sent += nwords + 1;
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/mh3_pkg.sv
design/mh3_fifo.sv
design/mh3_front.sv
design/mh3_back.sv
design/murmur3_hash_stream_top.sv
sim/testbench.sv
